// ===== hw/rtl/chb_pkg.sv =====
// Package for the cubic Hermite basis evaluator: widths, coefficient tables,
// the last basis index per cell kind and the function that derives per-basis
// polynomial coefficients. No dependencies.
`default_nettype none
package chb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 18;
    localparam int NMON          = 10;

    typedef logic signed [7:0] coef_t;
    typedef coef_t coef_vec_t [NMON];

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_TRI   = 2'd2,
        KIND_BAD   = 2'd3
    } cell_kind_t;

    typedef enum logic [1:0] {
        DIR_VAL = 2'd0,
        DIR_DX  = 2'd1,
        DIR_DY  = 2'd2
    } dir_t;

    // Monomial order: 1, x, y, x^2, xy, y^2, x^3, x^2y, xy^2, y^3
    localparam coef_t LINE_POLY [4][NMON] = '{
        '{8'sd1, 8'sd0, 8'sd0, -8'sd3, 8'sd0, 8'sd0,  8'sd2, 8'sd0, 8'sd0, 8'sd0},
        '{8'sd0, 8'sd1, 8'sd0, -8'sd2, 8'sd0, 8'sd0,  8'sd1, 8'sd0, 8'sd0, 8'sd0},
        '{8'sd0, 8'sd0, 8'sd0,  8'sd3, 8'sd0, 8'sd0, -8'sd2, 8'sd0, 8'sd0, 8'sd0},
        '{8'sd0, 8'sd0, 8'sd0, -8'sd1, 8'sd0, 8'sd0,  8'sd1, 8'sd0, 8'sd0, 8'sd0}
    };

    localparam coef_t TRI_POLY [10][NMON] = '{
        '{8'sd1, 8'sd0, 8'sd0, -8'sd3, -8'sd13, -8'sd3,  8'sd2,  8'sd13,  8'sd13,  8'sd2},
        '{8'sd0, 8'sd1, 8'sd0, -8'sd2, -8'sd3,   8'sd0,  8'sd1,  8'sd3,   8'sd2,   8'sd0},
        '{8'sd0, 8'sd0, 8'sd1,  8'sd0, -8'sd3,  -8'sd2,  8'sd0,  8'sd2,   8'sd3,   8'sd1},
        '{8'sd0, 8'sd0, 8'sd0,  8'sd3, -8'sd7,   8'sd0, -8'sd2,  8'sd7,   8'sd7,   8'sd0},
        '{8'sd0, 8'sd0, 8'sd0, -8'sd1,  8'sd2,   8'sd0,  8'sd1, -8'sd2,  -8'sd2,   8'sd0},
        '{8'sd0, 8'sd0, 8'sd0,  8'sd0, -8'sd1,   8'sd0,  8'sd0,  8'sd2,   8'sd1,   8'sd0},
        '{8'sd0, 8'sd0, 8'sd0,  8'sd0, -8'sd7,   8'sd3,  8'sd0,  8'sd7,   8'sd7,  -8'sd2},
        '{8'sd0, 8'sd0, 8'sd0,  8'sd0, -8'sd1,   8'sd0,  8'sd0,  8'sd1,   8'sd2,   8'sd0},
        '{8'sd0, 8'sd0, 8'sd0,  8'sd0,  8'sd2,  -8'sd1,  8'sd0, -8'sd2,  -8'sd2,   8'sd1},
        '{8'sd0, 8'sd0, 8'sd0,  8'sd0,  8'sd27,  8'sd0,  8'sd0, -8'sd27, -8'sd27,  8'sd0}
    };

    // Index of the final basis function for a cell kind.
    function automatic logic [3:0] last_index(input cell_kind_t kind);
        logic [3:0] r;
        case (kind)
            KIND_LINE: r = 4'd3;
            KIND_TRI:  r = 4'd9;
            default:   r = 4'd0;
        endcase
        return r;
    endfunction

    // Coefficients of the selected derivative of one basis polynomial.
    // A point cell yields the constant 1, an unsupported cell all zeros.
    function automatic coef_vec_t basis_coefs(input cell_kind_t kind,
                                              input logic [1:0] sel,
                                              input logic [3:0] idx);
        coef_vec_t p;
        coef_vec_t c;
        dir_t      dir;
        for (int m = 0; m < NMON; m++) begin
            c[m] = '0;
            p[m] = '0;
        end
        case (sel)
            2'd0:    dir = DIR_VAL;
            2'd1:    dir = DIR_DX;
            default: dir = DIR_DY;
        endcase
        case (kind)
            KIND_POINT:
            begin
                p[0] = 8'sd1;
                dir  = DIR_VAL;
            end
            KIND_LINE:
            begin
                p = LINE_POLY[idx[1:0]];
                if (dir != DIR_VAL)
                begin
                    dir = DIR_DX;
                end
            end
            KIND_TRI:
            begin
                if (idx < 4'd10)
                begin
                    p = TRI_POLY[idx];
                end
            end
            default:
            begin
                dir = DIR_VAL;
            end
        endcase
        case (dir)
            DIR_DX:
            begin
                c[0] = p[1];
                c[1] = coef_t'(p[3] * 2);
                c[2] = p[4];
                c[3] = coef_t'(p[6] * 3);
                c[4] = coef_t'(p[7] * 2);
                c[5] = p[8];
            end
            DIR_DY:
            begin
                c[0] = p[2];
                c[1] = p[4];
                c[2] = coef_t'(p[5] * 2);
                c[3] = p[7];
                c[4] = coef_t'(p[8] * 2);
                c[5] = coef_t'(p[9] * 3);
            end
            default:
            begin
                c = p;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cubic_hermite_basis_eval_unit.sv =====
// Top level of the cubic Hermite basis evaluator: sequencer and five-stage
// polynomial pipeline. Depends on chb_pkg.
//
// channel   direction  handshake               fields
// command   in         start && !busy          cell_kind deriv_select coord_x coord_y
// result    out        result_valid, 1 cycle   basis_index basis_value status last_of_point
//
// A point issues one basis index per cycle, one per basis function: 1 (point
// or unsupported cell), 4 (line) or 10 (triangle) indices. The next point is
// taken in the cycle its predecessor issues its last index. A result passes
// through stages 1 to 4 and the output register after issue. Reset clears the
// sequencer's active flag and the valid bits. Results cannot be stalled.
`default_nettype none
module cubic_hermite_basis_eval_unit #(
    parameter int FRAC_BITS = chb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   cell_kind,
    input  wire logic [1:0]                   deriv_select,
    input  wire logic signed [chb_pkg::COORD_W-1:0] coord_x,
    input  wire logic signed [chb_pkg::COORD_W-1:0] coord_y,
    output logic                              result_valid,
    output logic [3:0]                        basis_index,
    output logic signed [31:0]                basis_value,
    output logic                              status,
    output logic                              last_of_point
);
    import chb_pkg::*;

    localparam int SQ_W = 2 * COORD_W;        // x^2 and friends
    localparam int CU_W = 3 * COORD_W;        // cubes
    localparam int A_W  = 34;                 // constant and linear terms
    localparam int B_W  = 46;                 // quadratic sum
    localparam int C_W  = 62;                 // cubic sum
    localparam int T_W  = 64;
    localparam logic signed [T_W-1:0] HALF   = T_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [T_W-1:0] SAT_HI = T_W'(32'sh7FFFFFFF);
    localparam logic signed [T_W-1:0] SAT_LO = -T_W'(64'sh80000000);

    // sequencer
    logic                      act_reg, act_next;
    cell_kind_t                kind_reg, kind_next;
    logic [1:0]                sel_reg, sel_next;
    logic signed [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      issue_last;
    logic                      accept;

    assign issue_last = act_reg && (cnt_reg == last_index(kind_reg));
    assign busy       = act_reg && !issue_last;
    assign accept     = start && !busy;

    always_comb
    begin
        act_next  = act_reg;
        kind_next = kind_reg;
        sel_next  = sel_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            act_next  = 1'b1;
            kind_next = cell_kind_t'(cell_kind);
            sel_next  = deriv_select;
            x_next    = coord_x;
            y_next    = coord_y;
            cnt_next  = '0;
        end
        else if (issue_last)
        begin
            act_next = 1'b0;
        end
        else if (act_reg)
        begin
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        sel_reg  <= sel_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        cnt_reg  <= cnt_next;
    end

    // stage 1: coefficient lookup, squares
    logic                      v1_reg, idx_last1_reg, st1_reg;
    logic [3:0]                idx1_reg;
    logic signed [COORD_W-1:0] x1_reg, y1_reg;
    logic signed [SQ_W-1:0]    xx1_reg, xy1_reg, yy1_reg;
    coef_vec_t                 c1_reg;

    // stage 2: cubes, quadratic and linear sums
    logic                      v2_reg, last2_reg, st2_reg;
    logic [3:0]                idx2_reg;
    logic signed [CU_W-1:0]    xxx2_reg, xxy2_reg, xyy2_reg, yyy2_reg;
    logic signed [A_W-1:0]     a2_reg;
    logic signed [B_W-1:0]     b2_reg;
    coef_t                     c6_reg, c7_reg, c8_reg, c9_reg;

    // stage 3: cubic sum
    logic                      v3_reg, last3_reg, st3_reg;
    logic [3:0]                idx3_reg;
    logic signed [A_W-1:0]     a3_reg;
    logic signed [B_W-1:0]     b3_reg;
    logic signed [C_W-1:0]     cc3_reg;

    // stage 4: first rounding step
    logic                      v4_reg, last4_reg, st4_reg;
    logic [3:0]                idx4_reg;
    logic signed [A_W-1:0]     a4_reg;
    logic signed [T_W-1:0]     t4_reg;

    logic signed [T_W-1:0]     r5;
    logic signed [31:0]        sat5;

    always_comb
    begin
        r5 = T_W'(a4_reg) + (t4_reg >>> FRAC_BITS);
        if (r5 > SAT_HI)
        begin
            sat5 = 32'sh7FFFFFFF;
        end
        else if (r5 < SAT_LO)
        begin
            sat5 = 32'sh80000000;
        end
        else
        begin
            sat5 = r5[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            v1_reg       <= act_reg;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            result_valid <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg      <= cnt_reg;
        idx_last1_reg <= issue_last;
        st1_reg       <= (kind_reg == KIND_BAD);
        x1_reg        <= x_reg;
        y1_reg        <= (kind_reg == KIND_TRI) ? y_reg : '0;
        xx1_reg       <= SQ_W'(x_reg * x_reg);
        xy1_reg       <= SQ_W'(x_reg * y_reg);
        yy1_reg       <= SQ_W'(y_reg * y_reg);
        c1_reg        <= basis_coefs(kind_reg, sel_reg, cnt_reg);

        idx2_reg  <= idx1_reg;
        last2_reg <= idx_last1_reg;
        st2_reg   <= st1_reg;
        // a line ignores y: y1_reg is zero there, which drops the y-dependent cubes
        xxx2_reg  <= CU_W'(xx1_reg * x1_reg);
        xxy2_reg  <= CU_W'(xx1_reg * y1_reg);
        xyy2_reg  <= CU_W'(xy1_reg * y1_reg);
        yyy2_reg  <= CU_W'(yy1_reg * y1_reg);
        a2_reg    <= (A_W'(c1_reg[0]) <<< FRAC_BITS) + A_W'(c1_reg[1] * x1_reg)
                     + A_W'(c1_reg[2] * y1_reg);
        b2_reg    <= B_W'(c1_reg[3] * xx1_reg) + B_W'(c1_reg[4] * xy1_reg)
                     + B_W'(c1_reg[5] * yy1_reg);
        c6_reg    <= c1_reg[6];
        c7_reg    <= c1_reg[7];
        c8_reg    <= c1_reg[8];
        c9_reg    <= c1_reg[9];

        idx3_reg  <= idx2_reg;
        last3_reg <= last2_reg;
        st3_reg   <= st2_reg;
        a3_reg    <= a2_reg;
        b3_reg    <= b2_reg;
        cc3_reg   <= C_W'(c6_reg * xxx2_reg) + C_W'(c7_reg * xxy2_reg)
                     + C_W'(c8_reg * xyy2_reg) + C_W'(c9_reg * yyy2_reg);

        idx4_reg  <= idx3_reg;
        last4_reg <= last3_reg;
        st4_reg   <= st3_reg;
        a4_reg    <= a3_reg;
        // arithmetic shift is the floor division by 2^FRAC_BITS
        t4_reg    <= T_W'(b3_reg) + HALF + (T_W'(cc3_reg) >>> FRAC_BITS);

        basis_index   <= idx4_reg;
        basis_value   <= sat5;
        status        <= st4_reg;
        last_of_point <= last4_reg;
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 result_valid)
        else $error("accepted command gave no result six cycles later");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (last_of_point && basis_index == 4'd0
                                      && basis_value == 32'sd0))
        else $error("unsupported cell result malformed");

    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

endmodule
`default_nettype wire
